// ===== src/uniform_grid_cutoff_neighbor_lookup_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the grid cutoff neighbor lookup
// Shared concurrent-assertion forms, clocked on clk_i, disabled in reset.
// -----------------------------------------------------------------------------
`ifndef UNIFORM_GRID_CUTOFF_NEIGHBOR_LOOKUP_MACROS_SVH
`define UNIFORM_GRID_CUTOFF_NEIGHBOR_LOOKUP_MACROS_SVH

// condition holds at every edge
`define UCNL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define UCNL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UCNL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ucnl_pkg.sv =====
// -----------------------------------------------------------------------------
// ucnl_pkg
// Types and constants shared by the grid cutoff neighbor lookup.
// -----------------------------------------------------------------------------
package ucnl_pkg;

  localparam int ATOM_DEPTH = 4096;
  localparam int MAX_HITS   = 64;
  localparam int ATOM_AW    = (ATOM_DEPTH > 1) ? $clog2(ATOM_DEPTH) : 1;
  localparam int CNT_W      = ATOM_AW + 1;
  localparam int HIT_W      = $clog2(MAX_HITS + 1);
  localparam int CELL_UNITS = 768;
  localparam int RES_DEPTH  = 8;
  localparam int RES_AW     = $clog2(RES_DEPTH);
  localparam int DIV_W      = 40;
  localparam int DVS_W      = 24;
  localparam int N_W        = 15;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [2:0] CFG_BEGIN_X = 3'd0;
  localparam logic [2:0] CFG_BEGIN_Y = 3'd1;
  localparam logic [2:0] CFG_BEGIN_Z = 3'd2;
  localparam logic [2:0] CFG_END_X   = 3'd3;
  localparam logic [2:0] CFG_END_Y   = 3'd4;
  localparam logic [2:0] CFG_END_Z   = 3'd5;
  localparam logic [2:0] CFG_CUTOFF  = 3'd6;
  localparam logic [2:0] CFG_TYPELIM = 3'd7;

  typedef logic signed [23:0] coord_t;

  typedef struct packed {
    logic [1:0] op;
    coord_t     x;
    coord_t     y;
    coord_t     z;
    logic [7:0] kind;
  } item_t;

  typedef struct packed {
    coord_t [2:0] bgn;
    coord_t [2:0] fin;
    logic [31:0]  cutoff;
    logic [7:0]   type_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [24:0] lo;
    logic signed [24:0] hi;
  } span_t;

  typedef struct packed {
    logic [11:0] idx;
    logic        last;
    logic        empty;
    logic        over;
  } res_t;

endpackage

// ===== src/ucnl_div.sv =====
// -----------------------------------------------------------------------------
// ucnl_div
// Restoring unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module ucnl_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ucnl_pkg::DIV_W-1:0] dividend_i,
  input  logic [ucnl_pkg::DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [ucnl_pkg::DIV_W-1:0] quot_o
);
  import ucnl_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DVS_W:0]   rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   sh, diff;
  logic             ge, last;

  assign sh   = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
  assign ge   = sh >= {1'b0, dvs_q};
  assign diff = sh - {1'b0, dvs_q};
  assign last = cnt_q == CW'(DIV_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff : sh;
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== src/ucnl_geom.sv =====
// -----------------------------------------------------------------------------
// ucnl_geom
// Cell bounds of the query point, axis by axis, on one shared divider.
// -----------------------------------------------------------------------------
module ucnl_geom (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  ucnl_pkg::cfg_t          cfg_i,
  input  ucnl_pkg::coord_t [2:0]  pos_i,
  output logic                    done_o,
  output ucnl_pkg::span_t [2:0]   span_o
);
  import ucnl_pkg::*;

  localparam logic [3:0] G_IDLE = 4'd0;
  localparam logic [3:0] G_AXIS = 4'd1;
  localparam logic [3:0] G_IDXS = 4'd3;
  localparam logic [3:0] G_IDX  = 4'd4;
  localparam logic [3:0] G_LOS  = 4'd5;
  localparam logic [3:0] G_LO   = 4'd6;
  localparam logic [3:0] G_HIS  = 4'd7;
  localparam logic [3:0] G_HI   = 4'd8;
  localparam logic [3:0] G_NEXT = 4'd9;

  logic [3:0]       state_q;
  logic [1:0]       axis_q;
  logic [DVS_W-1:0] ext_q;
  logic [N_W-1:0]   n_q, idx_q, nm1;
  logic [N_W:0]     idx1;
  span_t [2:0]      span_q;
  logic             done_q;

  logic signed [24:0] bgn_w, fin_w, pos_w, ext_w, num_w, q_w;
  logic               ext_pos, num_pos;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dvd, div_q;
  logic [DVS_W-1:0]   div_dvs;
  logic [31:0]        n_prod;
  logic [N_W-1:0]     n_w;

  assign bgn_w   = $signed({cfg_i.bgn[axis_q][23], cfg_i.bgn[axis_q]});
  assign fin_w   = $signed({cfg_i.fin[axis_q][23], cfg_i.fin[axis_q]});
  assign pos_w   = $signed({pos_i[axis_q][23], pos_i[axis_q]});
  assign ext_w   = fin_w - bgn_w;
  assign num_w   = pos_w - bgn_w;
  assign ext_pos = !ext_w[24] && (ext_w != '0);
  assign num_pos = !num_w[24] && (num_w != '0);
  assign nm1     = n_q - N_W'(1);
  assign idx1    = {1'b0, idx_q} + (N_W+1)'(1);
  assign q_w     = bgn_w + $signed({1'b0, div_q[DVS_W-1:0]});

  // extent / 768 = (extent >> 8) / 3, exact for a 16-bit operand
  assign n_prod  = {16'd0, ext_w[23:8]} * 32'd43691;
  assign n_w     = n_prod[31:17];

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_q)
      G_IDXS: begin
        div_start = num_pos;
        div_dvd   = DIV_W'(num_w[24:0]) * DIV_W'(n_q);
        div_dvs   = ext_q;
      end
      G_LOS: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(ext_q) * DIV_W'(idx_q);
        div_dvs   = DVS_W'(n_q);
      end
      G_HIS: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(ext_q) * DIV_W'(idx1);
        div_dvs   = DVS_W'(n_q);
      end
      default: ;
    endcase
  end

  ucnl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      axis_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        G_IDLE: if (start_i) begin
          axis_q  <= '0;
          state_q <= G_AXIS;
        end
        G_AXIS: state_q <= ext_pos ? G_IDXS : G_NEXT;
        G_IDXS: state_q <= num_pos ? G_IDX : G_LOS;
        G_IDX:  if (div_done) state_q <= G_LOS;
        G_LOS:  state_q <= G_LO;
        G_LO:   if (div_done) state_q <= G_HIS;
        G_HIS:  state_q <= G_HI;
        G_HI:   if (div_done) state_q <= G_NEXT;
        G_NEXT: begin
          if (axis_q == 2'd2) begin
            done_q  <= 1'b1;
            state_q <= G_IDLE;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= G_AXIS;
          end
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      G_AXIS: begin
        ext_q <= ext_w[DVS_W-1:0];
        n_q   <= (n_w == '0) ? N_W'(1) : n_w;
        if (!ext_pos) begin
          span_q[axis_q].lo <= bgn_w;
          span_q[axis_q].hi <= fin_w;
        end
      end
      G_IDXS: if (!num_pos) idx_q <= '0;
      G_IDX:  if (div_done) idx_q <= (div_q >= DIV_W'(nm1)) ? nm1 : div_q[N_W-1:0];
      G_LO:   if (div_done) span_q[axis_q].lo <= q_w;
      G_HI:   if (div_done) span_q[axis_q].hi <= q_w;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign span_o = span_q;

endmodule

// ===== src/ucnl_front.sv =====
// -----------------------------------------------------------------------------
// ucnl_front
// Input side: accepts items, drops unused operation codes, two-entry queue.
// -----------------------------------------------------------------------------
module ucnl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ucnl_pkg::item_t item_i,
  output logic            item_valid_o,
  output ucnl_pkg::item_t item_o,
  input  logic            item_pop_i
);
  import ucnl_pkg::*;

  item_t      buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       acc, push, pop;

  assign in_stall_o   = cnt_q == 2'd2;
  assign acc          = in_valid_i && !in_stall_o;
  assign push         = acc && (item_i.op == OP_LOAD || item_i.op == OP_CLEAR
                               || item_i.op == OP_QUERY);
  assign item_valid_o = cnt_q != 2'd0;
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= item_i;
  end

endmodule

// ===== src/ucnl_back.sv =====
// -----------------------------------------------------------------------------
// ucnl_back
// Atom store, query scan pipeline and result queue.
// -----------------------------------------------------------------------------
`include "uniform_grid_cutoff_neighbor_lookup_macros.svh"

module ucnl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ucnl_pkg::cfg_t  cfg_i,
  input  logic            item_valid_i,
  input  ucnl_pkg::item_t item_i,
  output logic            item_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ucnl_pkg::res_t  res_o
);
  import ucnl_pkg::*;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_GEOM  = 2'd1;
  localparam logic [1:0] B_SCAN  = 2'd2;
  localparam logic [1:0] B_DRAIN = 2'd3;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    coord_t     z;
    logic [7:0] kind;
  } atom_t;

  function automatic logic [24:0] axis_dist(coord_t p, logic signed [24:0] lo,
                                            logic signed [24:0] hi);
    logic signed [25:0] pe, le, he, d;
    pe = {{2{p[23]}}, p};
    le = {lo[24], lo};
    he = {hi[24], hi};
    if (pe < le)      d = le - pe;
    else if (pe > he) d = pe - he;
    else              d = '0;
    return d[24:0];
  endfunction

  atom_t mem [ATOM_DEPTH];

  logic [1:0]       state_q;
  logic [CNT_W-1:0] count_q, ptr_q;
  coord_t [2:0]     qpos_q;
  logic             stop_q, held_v_q;
  logic [11:0]      held_q;
  logic [HIT_W-1:0] hit_cnt_q;

  logic               v1_q, v2_q, v3_q;
  logic [ATOM_AW-1:0] idx1_q, idx2_q, idx3_q;
  atom_t              rd_q;
  logic [24:0]        dx_q, dy_q, dz_q;
  logic               ok2_q, ok3_q;
  logic [49:0]        sqx_q, sqy_q, sqz_q;

  res_t              fifo_q [RES_DEPTH];
  logic [RES_AW-1:0] wp_q, rp_q;
  logic [RES_AW:0]   fifo_cnt_q;

  logic               geom_start, geom_done;
  span_t [2:0]        span;
  logic               pop_item, issue, hit3, hit_take, final_go, push, pop_res;
  logic [1:0]         inflight;
  logic [51:0]        sum3;
  logic [ATOM_AW+11:0] idx_wide;
  logic [11:0]        hidx3;
  res_t               push_res;

  assign pop_item   = state_q == B_IDLE && item_valid_i;
  assign item_pop_o = pop_item;
  assign geom_start = pop_item && item_i.op == OP_QUERY;

  ucnl_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (geom_start),
    .cfg_i   (cfg_i),
    .pos_i   (qpos_q),
    .done_o  (geom_done),
    .span_o  (span)
  );

  assign inflight = 2'(v1_q) + 2'(v2_q) + 2'(v3_q);
  assign issue    = state_q == B_SCAN && !stop_q && ptr_q < count_q
                    && (fifo_cnt_q + (RES_AW+1)'(inflight)) < (RES_AW+1)'(RES_DEPTH - 1);
  assign sum3     = 52'(sqx_q) + 52'(sqy_q) + 52'(sqz_q);
  assign hit3     = v3_q && ok3_q && sum3 < 52'(cfg_i.cutoff);
  assign hit_take = hit3 && !stop_q && held_v_q;
  assign final_go = state_q == B_SCAN && !stop_q && ptr_q == count_q && inflight == 2'd0
                    && fifo_cnt_q != (RES_AW+1)'(RES_DEPTH);
  assign idx_wide = {12'b0, idx3_q};
  assign hidx3    = idx_wide[11:0];

  always_comb begin
    push     = 1'b0;
    push_res = '0;
    if (hit_take) begin
      push           = 1'b1;
      push_res.idx   = held_q;
      push_res.last  = hit_cnt_q == HIT_W'(MAX_HITS);
      push_res.over  = hit_cnt_q == HIT_W'(MAX_HITS);
    end else if (final_go) begin
      push           = 1'b1;
      push_res.idx   = held_v_q ? held_q : 12'd0;
      push_res.last  = 1'b1;
      push_res.empty = !held_v_q;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      stop_q    <= 1'b0;
      held_v_q  <= 1'b0;
      hit_cnt_q <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (issue) ptr_q <= ptr_q + CNT_W'(1);
      if (hit3 && !stop_q) begin
        if (!held_v_q) begin
          held_v_q  <= 1'b1;
          hit_cnt_q <= HIT_W'(1);
        end else if (hit_cnt_q == HIT_W'(MAX_HITS)) begin
          held_v_q <= 1'b0;
          stop_q   <= 1'b1;
        end else begin
          hit_cnt_q <= hit_cnt_q + HIT_W'(1);
        end
      end
      unique case (state_q)
        B_IDLE: if (pop_item) begin
          case (item_i.op)
            OP_LOAD:  if (count_q < CNT_W'(ATOM_DEPTH)) count_q <= count_q + CNT_W'(1);
            OP_CLEAR: count_q <= '0;
            OP_QUERY: begin
              state_q   <= B_GEOM;
              ptr_q     <= '0;
              stop_q    <= 1'b0;
              held_v_q  <= 1'b0;
              hit_cnt_q <= '0;
            end
            default: ;
          endcase
        end
        B_GEOM:  if (geom_done) state_q <= B_SCAN;
        B_SCAN: begin
          if (stop_q)        state_q <= B_DRAIN;
          else if (final_go) state_q <= B_IDLE;
        end
        B_DRAIN: if (inflight == 2'd0) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (pop_item && item_i.op == OP_QUERY) qpos_q <= {item_i.z, item_i.y, item_i.x};
    if (hit3 && !stop_q) held_q <= hidx3;
    idx1_q <= ptr_q[ATOM_AW-1:0];
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    dx_q   <= axis_dist(rd_q.x, span[0].lo, span[0].hi);
    dy_q   <= axis_dist(rd_q.y, span[1].lo, span[1].hi);
    dz_q   <= axis_dist(rd_q.z, span[2].lo, span[2].hi);
    ok2_q  <= rd_q.kind < cfg_i.type_limit;
    ok3_q  <= ok2_q;
    sqx_q  <= dx_q * dx_q;
    sqy_q  <= dy_q * dy_q;
    sqz_q  <= dz_q * dz_q;
  end

  // atom store
  always_ff @(posedge clk_i) begin
    if (pop_item && item_i.op == OP_LOAD && count_q < CNT_W'(ATOM_DEPTH)) begin
      mem[count_q[ATOM_AW-1:0]] <= {item_i.x, item_i.y, item_i.z, item_i.kind};
    end
    if (issue) rd_q <= mem[ptr_q[ATOM_AW-1:0]];
  end

  // result queue
  assign out_valid_o = fifo_cnt_q != '0;
  assign pop_res     = out_valid_o && !out_stall_i;
  assign res_o       = fifo_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      rp_q       <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push)    wp_q <= wp_q + RES_AW'(1);
      if (pop_res) rp_q <= rp_q + RES_AW'(1);
      fifo_cnt_q <= fifo_cnt_q + (RES_AW+1)'(push) - (RES_AW+1)'(pop_res);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= push_res;
  end

  `UCNL_ASSERT(a_credit, ({1'b0, fifo_cnt_q} + (RES_AW+2)'(inflight)) <= (RES_AW+2)'(RES_DEPTH), "result queue credit exceeded")
  `UCNL_ASSERT(a_hit_cap, hit_cnt_q <= HIT_W'(MAX_HITS), "hit count above cap")
  `UCNL_ASSERT_IMP(a_no_issue_stop, issue, !stop_q && state_q == B_SCAN, "issue after stop")
  `UCNL_ASSERT_NXT(a_final_idle, final_go, state_q == B_IDLE && !v1_q, "scan did not end")

endmodule

// ===== src/uniform_grid_cutoff_neighbor_lookup.sv =====
// -----------------------------------------------------------------------------
// uniform_grid_cutoff_neighbor_lookup
// Atom store with cutoff lookup around the grid cell of a query point.
// -----------------------------------------------------------------------------
// A query first finds its cell bounds: the cell count of an axis comes
// from a reciprocal multiplication, then a shared 40-step serial divider
// runs up to three divisions per axis, then the atom store streams at one
// atom per cycle through a distance pipeline. Results wait in an
// eight-entry queue, and the scan pauses while queued results and atoms
// in flight leave fewer than two free entries; a two-entry input queue
// lets new items arrive while a query runs.
module uniform_grid_cutoff_neighbor_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] pos_z_i,
  input  logic [7:0]  atom_kind_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] hit_index_o,
  output logic        is_last_o,
  output logic        is_empty_o,
  output logic        overflowed_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import ucnl_pkg::*;

  cfg_t  cfg_q;
  item_t in_item, q_item;
  logic  q_valid, q_pop;
  res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bgn        <= '0;
      cfg_q.fin        <= {3{24'sd7680}};
      cfg_q.cutoff     <= 32'd4194304;
      cfg_q.type_limit <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BEGIN_X: cfg_q.bgn[0]     <= cfg_data_i[23:0];
        CFG_BEGIN_Y: cfg_q.bgn[1]     <= cfg_data_i[23:0];
        CFG_BEGIN_Z: cfg_q.bgn[2]     <= cfg_data_i[23:0];
        CFG_END_X:   cfg_q.fin[0]     <= cfg_data_i[23:0];
        CFG_END_Y:   cfg_q.fin[1]     <= cfg_data_i[23:0];
        CFG_END_Z:   cfg_q.fin[2]     <= cfg_data_i[23:0];
        CFG_CUTOFF:  cfg_q.cutoff     <= cfg_data_i;
        CFG_TYPELIM: cfg_q.type_limit <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{op: operation_i, x: pos_x_i, y: pos_y_i, z: pos_z_i,
                     kind: atom_kind_i};

  ucnl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (in_item),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .item_pop_i   (q_pop)
  );

  ucnl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign hit_index_o  = res.idx;
  assign is_last_o    = res.last;
  assign is_empty_o   = res.empty;
  assign overflowed_o = res.over;

endmodule
